// File: rtl/bchc_pkg.sv
`timescale 1ns / 1ps
// Package for the button click/hold classifier.
// Holds the per-button state entry type, configuration type and register indexes.
package bchc_pkg;

    localparam int BTN_IDX_W = 2;
    localparam int TIME_W    = 32;
    localparam int DEB_W     = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_THR      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOT_HOLD_THR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOT_INDEX    = 3'd3;

    localparam logic [TIME_W-1:0]    HOLD_THR_RST      = 32'd2000;
    localparam logic [TIME_W-1:0]    BOOT_HOLD_THR_RST = 32'd5000;
    localparam logic [DEB_W-1:0]     DEBOUNCE_RST      = 16'd50;
    localparam logic [BTN_IDX_W-1:0] BOOT_INDEX_RST    = 2'd0;

    typedef struct packed {
        logic              pressed;
        logic              click_seen;
        logic              hold_seen;
        logic [TIME_W-1:0] press_start_ms;
    } entry_t;

    typedef struct packed {
        logic [TIME_W-1:0]    hold_limit_ms;
        logic [TIME_W-1:0]    boot_hold_limit_ms;
        logic [DEB_W-1:0]     debounce_ms;
        logic [BTN_IDX_W-1:0] boot_button_index;
    } cfg_t;

    typedef struct packed {
        logic [BTN_IDX_W-1:0] button_index;
        logic                 edge_event;
        logic                 level_at_edge;
        logic                 level_settled;
        logic [TIME_W-1:0]    now_ms;
        logic                 clear_flags;
    } item_t;

endpackage

// File: rtl/bchc_state_mem.sv
`timescale 1ns / 1ps
// Per-button state memory: one write port, one registered read port.
// Entries never written since reset read as zero through per-entry valid bits. Uses bchc_pkg.
module bchc_state_mem #(
    parameter int DEPTH  = 4,
    parameter int ADDR_W = 2
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output bchc_pkg::entry_t    rd_data,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  bchc_pkg::entry_t    wr_data
);
    import bchc_pkg::*;

    entry_t             mem [DEPTH];
    logic [DEPTH-1:0]   valid_reg;
    entry_t             rd_data_reg;
    logic               rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// File: rtl/bchc_classify.sv
`timescale 1ns / 1ps
// Press/release classification for one transaction against one state entry.
// Produces the reported flags and the entry to write back. Uses bchc_pkg.
module bchc_classify (
    input  bchc_pkg::entry_t entry_in,
    input  bchc_pkg::item_t  item,
    input  bchc_pkg::cfg_t   cfg,
    output bchc_pkg::entry_t entry_out,
    output logic             click_flag,
    output logic             hold_flag
);
    import bchc_pkg::*;

    entry_t            upd;
    logic [TIME_W-1:0] held;
    logic [TIME_W-1:0] thr;

    assign held = item.now_ms - entry_in.press_start_ms;
    assign thr  = (item.button_index == cfg.boot_button_index) ?
                  cfg.boot_hold_limit_ms : cfg.hold_limit_ms;

    always_comb begin
        upd = entry_in;
        if (item.edge_event && (item.level_at_edge == item.level_settled)) begin
            if (!item.level_at_edge) begin
                upd.press_start_ms = item.now_ms;
                upd.pressed        = 1'b1;
            end else begin
                if (entry_in.pressed) begin
                    if (held >= thr) begin
                        upd.hold_seen = 1'b1;
                    end else if (held > {{(TIME_W-DEB_W){1'b0}}, cfg.debounce_ms}) begin
                        upd.click_seen = 1'b1;
                    end
                end
                upd.pressed = 1'b0;
            end
        end
        entry_out = upd;
        if (item.clear_flags) begin
            entry_out.click_seen = 1'b0;
            entry_out.hold_seen  = 1'b0;
        end
    end

    assign click_flag = upd.click_seen;
    assign hold_flag  = upd.hold_seen;

endmodule

// File: rtl/button_click_hold_classifier_top.sv
`timescale 1ns / 1ps
// Button click/hold classifier, top level.
// Instantiates bchc_state_mem and bchc_classify; uses bchc_pkg.
//
// Usage:
//   Input channel s_*: one transaction per button event (or poll) with the
//   button index, edge levels, millisecond timestamp and a clear request.
//   Result channel m_*: one transaction per input with the button's sticky
//   click and hold flags, edge update included, before any clear.
//   Configuration: cfg_we/cfg_index/cfg_wdata write thresholds and the boot
//   button index; write only while the block is idle.
//   Result path: the state memory read and the stage-1 input register both
//   capture at the accepting edge; classify then feeds the output register
//   when that register can take a new result.
//   Throughput: one transaction per cycle unless m_ready stalls, set by the
//   single read and write ports of the state memory; the last write is
//   forwarded so back-to-back events on one button see current state.
//   Reset: aresetn clears configuration to defaults, the memory valid bits
//   (all buttons released, flags clear) and both pipeline stages.
//   Stall: when m_ready is low the result holds, the stage behind it holds,
//   and s_ready drops once both stages are full.
module button_click_hold_classifier_top #(
    parameter int NUM_BUTTONS = 4
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [bchc_pkg::BTN_IDX_W-1:0]     s_button_index,
    input  logic                               s_edge_event,
    input  logic                               s_level_at_edge,
    input  logic                               s_level_settled,
    input  logic [bchc_pkg::TIME_W-1:0]        s_now_ms,
    input  logic                               s_clear_flags,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_click_flag,
    output logic                               m_hold_flag,
    input  logic                               cfg_we,
    input  logic [bchc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bchc_pkg::CFG_DAT_W-1:0]     cfg_wdata
);
    import bchc_pkg::*;

    localparam int ADDR_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

    cfg_t              cfg_reg;
    item_t             s1_item_reg;
    logic              s1_vld_reg;
    logic              s1_in_range_reg;
    logic              m_vld_reg;
    logic              m_click_reg;
    logic              m_hold_reg;
    logic              fwd_vld_reg;
    logic [ADDR_W-1:0] fwd_addr_reg;
    entry_t            fwd_data_reg;

    logic              in_accept;
    logic              out_ready;
    logic              s1_advance;
    logic              in_range;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] s1_addr;
    entry_t            mem_rd_data;
    entry_t            cur_entry;
    entry_t            new_entry;
    logic              cls_click;
    logic              cls_hold;
    logic              wr_en;

    assign out_ready  = !m_vld_reg || m_ready;
    assign s1_advance = s1_vld_reg && out_ready;
    assign s_ready    = !s1_vld_reg || out_ready;
    assign in_accept  = s_valid && s_ready;
    assign in_range   = 32'(s_button_index) < NUM_BUTTONS;
    assign rd_addr    = ADDR_W'(s_button_index);
    assign s1_addr    = ADDR_W'(s1_item_reg.button_index);
    assign wr_en      = s1_advance && s1_in_range_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.hold_limit_ms      <= HOLD_THR_RST;
            cfg_reg.boot_hold_limit_ms <= BOOT_HOLD_THR_RST;
            cfg_reg.debounce_ms        <= DEBOUNCE_RST;
            cfg_reg.boot_button_index  <= BOOT_INDEX_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_HOLD_THR:      cfg_reg.hold_limit_ms      <= cfg_wdata;
                CFG_BOOT_HOLD_THR: cfg_reg.boot_hold_limit_ms <= cfg_wdata;
                CFG_DEBOUNCE:      cfg_reg.debounce_ms        <= cfg_wdata[DEB_W-1:0];
                CFG_BOOT_INDEX:    cfg_reg.boot_button_index  <= cfg_wdata[BTN_IDX_W-1:0];
                default: begin
                end
            endcase
        end
    end

    bchc_state_mem #(
        .DEPTH  (NUM_BUTTONS),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (in_accept),
        .rd_addr (rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (wr_en),
        .wr_addr (s1_addr),
        .wr_data (new_entry)
    );

    // forward the most recent write over the memory read
    assign cur_entry = (fwd_vld_reg && (fwd_addr_reg == s1_addr)) ? fwd_data_reg : mem_rd_data;

    bchc_classify u_classify (
        .entry_in   (cur_entry),
        .item       (s1_item_reg),
        .cfg        (cfg_reg),
        .entry_out  (new_entry),
        .click_flag (cls_click),
        .hold_flag  (cls_hold)
    );

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            s1_item_reg.button_index  <= s_button_index;
            s1_item_reg.edge_event    <= s_edge_event;
            s1_item_reg.level_at_edge <= s_level_at_edge;
            s1_item_reg.level_settled <= s_level_settled;
            s1_item_reg.now_ms        <= s_now_ms;
            s1_item_reg.clear_flags   <= s_clear_flags;
            s1_in_range_reg           <= in_range;
        end
        if (s1_advance) begin
            m_click_reg <= s1_in_range_reg && cls_click;
            m_hold_reg  <= s1_in_range_reg && cls_hold;
        end
        if (wr_en) begin
            fwd_addr_reg <= s1_addr;
            fwd_data_reg <= new_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg  <= 1'b0;
            m_vld_reg   <= 1'b0;
            fwd_vld_reg <= 1'b0;
        end else begin
            if (in_accept) begin
                s1_vld_reg <= 1'b1;
            end else if (s1_advance) begin
                s1_vld_reg <= 1'b0;
            end
            if (s1_advance) begin
                m_vld_reg <= 1'b1;
            end else if (m_ready) begin
                m_vld_reg <= 1'b0;
            end
            if (wr_en) begin
                fwd_vld_reg <= 1'b1;
            end
        end
    end

    assign m_valid      = m_vld_reg;
    assign m_click_flag = m_click_reg;
    assign m_hold_flag  = m_hold_reg;

    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_vld_reg && !out_ready) |=> (s1_vld_reg && $stable(s1_item_reg)))
        else $error("stalled stage changed");

    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> s1_vld_reg)
        else $error("accepted transaction lost");

    a_oob_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_advance && !s1_in_range_reg) |=> (m_valid && !m_click_flag && !m_hold_flag))
        else $error("out-of-range button reported a flag");

    a_wr_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (32'(s1_item_reg.button_index) < NUM_BUTTONS))
        else $error("state write to out-of-range button");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for button_click_hold_classifier_top: directed and random
// button events with random gaps and backpressure. Depends on bchc_pkg and the RTL top.
module testbench;
    import bchc_pkg::*;

    localparam int NUM_BUTTONS = 4;
    localparam int STALL_LIMIT = 1000;
    localparam int PHASE_ITEMS = 215;

    typedef struct packed {
        logic click;
        logic hold;
    } flag_pair_t;

    class button_flag_scoreboard;
        logic [TIME_W-1:0]    hold_thr;
        logic [TIME_W-1:0]    boot_hold_thr;
        logic [DEB_W-1:0]     debounce;
        logic [BTN_IDX_W-1:0] boot_button;
        bit                   pressed     [NUM_BUTTONS];
        logic [TIME_W-1:0]    press_start [NUM_BUTTONS];
        bit                   click_seen  [NUM_BUTTONS];
        bit                   hold_seen   [NUM_BUTTONS];
        flag_pair_t           expected_flags[$];
        int unsigned          mismatches;

        function new();
            hold_thr      = HOLD_THR_RST;
            boot_hold_thr = BOOT_HOLD_THR_RST;
            debounce      = DEBOUNCE_RST;
            boot_button   = BOOT_INDEX_RST;
            mismatches    = 0;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                pressed[i]     = 1'b0;
                press_start[i] = '0;
                click_seen[i]  = 1'b0;
                hold_seen[i]   = 1'b0;
            end
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
            case (idx)
                CFG_HOLD_THR:      hold_thr      = data;
                CFG_BOOT_HOLD_THR: boot_hold_thr = data;
                CFG_DEBOUNCE:      debounce      = data[DEB_W-1:0];
                CFG_BOOT_INDEX:    boot_button   = data[BTN_IDX_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_event(item_t it);
            flag_pair_t        f;
            logic [TIME_W-1:0] held;
            logic [TIME_W-1:0] thr;
            int                b;
            b = int'(it.button_index);
            f = '0;
            if (b < NUM_BUTTONS) begin
                if (it.edge_event && it.level_at_edge == it.level_settled) begin
                    if (!it.level_at_edge) begin
                        press_start[b] = it.now_ms;
                        pressed[b]     = 1'b1;
                    end else begin
                        if (pressed[b]) begin
                            held = it.now_ms - press_start[b];
                            thr  = (b == boot_button) ? boot_hold_thr : hold_thr;
                            if (held >= thr)
                                hold_seen[b] = 1'b1;
                            else if (held > {16'd0, debounce})
                                click_seen[b] = 1'b1;
                        end
                        pressed[b] = 1'b0;
                    end
                end
                f.click = click_seen[b];
                f.hold  = hold_seen[b];
                if (it.clear_flags) begin
                    click_seen[b] = 1'b0;
                    hold_seen[b]  = 1'b0;
                end
            end
            expected_flags.push_back(f);
        endfunction

        function void check_flags(logic click, logic hold);
            flag_pair_t f;
            if (expected_flags.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual click %0b hold %0b",
                         $time, click, hold);
                mismatches++;
            end else begin
                f = expected_flags.pop_front();
                if (click !== f.click) begin
                    $display("%0t: click_flag mismatch, expected %0b, actual %0b",
                             $time, f.click, click);
                    mismatches++;
                end
                if (hold !== f.hold) begin
                    $display("%0t: hold_flag mismatch, expected %0b, actual %0b",
                             $time, f.hold, hold);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    logic [BTN_IDX_W-1:0]   s_button_index;
    logic                   s_edge_event;
    logic                   s_level_at_edge;
    logic                   s_level_settled;
    logic [TIME_W-1:0]      s_now_ms;
    logic                   s_clear_flags;
    logic                   m_valid;
    logic                   m_ready;
    logic                   m_click_flag;
    logic                   m_hold_flag;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DAT_W-1:0]   cfg_wdata;

    button_flag_scoreboard  sb;
    bit                     gaps_on;
    int unsigned            stall_cycles = 0;
    bit                     stim_down     [NUM_BUTTONS];
    logic [TIME_W-1:0]      stim_press_ms [NUM_BUTTONS];

    button_click_hold_classifier_top #(
        .NUM_BUTTONS(NUM_BUTTONS)
    ) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_button_index (s_button_index),
        .s_edge_event   (s_edge_event),
        .s_level_at_edge(s_level_at_edge),
        .s_level_settled(s_level_settled),
        .s_now_ms       (s_now_ms),
        .s_clear_flags  (s_clear_flags),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_click_flag   (m_click_flag),
        .m_hold_flag    (m_hold_flag),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        if (m_valid && m_ready)
            sb.check_flags(m_click_flag, m_hold_flag);
        m_ready <= !gaps_on || ($urandom_range(99) >= 31);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT) begin
            $display("button_click_hold_classifier_top verification failed");
            $finish;
        end else
            stall_cycles <= stall_cycles + 1;
    end

    function automatic item_t make_item(int b, bit e, bit le, bit ls, logic [TIME_W-1:0] now,
                                        bit clr);
        item_t it;
        it.button_index  = BTN_IDX_W'(b);
        it.edge_event    = e;
        it.level_at_edge = le;
        it.level_settled = ls;
        it.now_ms        = now;
        it.clear_flags   = clr;
        return it;
    endfunction

    // Mostly press/release pairs per button, with durations often near the thresholds.
    function automatic item_t make_random_event();
        item_t             it;
        int unsigned       pick;
        int                b;
        logic [TIME_W-1:0] thr;
        logic [TIME_W-1:0] span;
        b    = $urandom_range(NUM_BUTTONS - 1);
        it   = make_item(b, 1'b1, 1'b0, 1'b0, $urandom, ($urandom_range(3) == 0));
        thr  = (b == sb.boot_button) ? sb.boot_hold_thr : sb.hold_thr;
        pick = $urandom_range(99);
        if (pick < 80 && stim_down[b]) begin
            case ($urandom_range(4))
                0:       span = thr + $urandom_range(4) - 2;
                1:       span = {16'd0, sb.debounce} + $urandom_range(4) - 2;
                2:       span = $urandom_range(thr, 0);
                3:       span = $urandom;
                default: span = $urandom_range(200);
            endcase
            it.level_at_edge = 1'b1;
            it.level_settled = 1'b1;
            it.now_ms        = stim_press_ms[b] + span;
            stim_down[b]     = 1'b0;
        end else if (pick < 86) begin
            stim_down[b]     = 1'b1;
            stim_press_ms[b] = it.now_ms;
        end else if (pick < 92) begin
            it.level_at_edge = 1'($urandom_range(1));
            it.level_settled = !it.level_at_edge;
        end else if (pick < 97) begin
            it.edge_event    = 1'b0;
            it.level_at_edge = 1'($urandom_range(1));
            it.level_settled = 1'($urandom_range(1));
        end else begin
            it.level_at_edge = 1'b1;
            it.level_settled = 1'b1;
            stim_down[b]     = 1'b0;
        end
        return it;
    endfunction

    task automatic send_event(input item_t it);
        while (gaps_on && $urandom_range(99) < 31) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_button_index  <= it.button_index;
        s_edge_event    <= it.edge_event;
        s_level_at_edge <= it.level_at_edge;
        s_level_settled <= it.level_settled;
        s_now_ms        <= it.now_ms;
        s_clear_flags   <= it.clear_flags;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sb.note_event(it);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (sb.expected_flags.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        sb.write_register(idx, data);
    endtask

    task automatic apply_settings(input cfg_t c);
        write_reg(CFG_HOLD_THR, c.hold_limit_ms);
        write_reg(CFG_BOOT_HOLD_THR, c.boot_hold_limit_ms);
        write_reg(CFG_DEBOUNCE, {16'($urandom), c.debounce_ms});
        write_reg(CFG_BOOT_INDEX, {30'($urandom), c.boot_button_index});
        cfg_we <= 1'b0;
    endtask

    initial begin
        cfg_t settings [6];
        sb      = new();
        gaps_on = 1'b1;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            stim_down[i]     = 1'b0;
            stim_press_ms[i] = '0;
        end
        aresetn         <= 1'b0;
        s_valid         <= 1'b0;
        s_button_index  <= '0;
        s_edge_event    <= 1'b0;
        s_level_at_edge <= 1'b1;
        s_level_settled <= 1'b1;
        s_now_ms        <= '0;
        s_clear_flags   <= 1'b0;
        m_ready         <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= '0;
        cfg_wdata       <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset thresholds: hold 2000, boot 5000 on button 0, debounce 50
        send_event(make_item(0, 1'b0, 1'b0, 1'b0, 32'd0, 1'b0));
        send_event(make_item(0, 1'b1, 1'b0, 1'b0, 32'd0, 1'b0));
        send_event(make_item(0, 1'b1, 1'b1, 1'b1, 32'd5000, 1'b1));
        send_event(make_item(0, 1'b0, 1'b1, 1'b1, 32'd7, 1'b0));
        send_event(make_item(1, 1'b1, 1'b0, 1'b0, 32'hFFFF_FFF0, 1'b0));
        send_event(make_item(1, 1'b1, 1'b1, 1'b1, 32'h0000_00F0, 1'b0));
        send_event(make_item(1, 1'b0, 1'b0, 1'b1, 32'd0, 1'b1));
        send_event(make_item(2, 1'b1, 1'b0, 1'b0, 32'd100, 1'b0));
        send_event(make_item(2, 1'b1, 1'b1, 1'b1, 32'd150, 1'b0));
        send_event(make_item(2, 1'b1, 1'b0, 1'b0, 32'd100, 1'b0));
        send_event(make_item(2, 1'b1, 1'b1, 1'b1, 32'd151, 1'b0));
        send_event(make_item(2, 1'b1, 1'b0, 1'b0, 32'd100, 1'b0));
        send_event(make_item(2, 1'b1, 1'b1, 1'b1, 32'd2099, 1'b1));
        send_event(make_item(2, 1'b1, 1'b0, 1'b0, 32'd100, 1'b0));
        send_event(make_item(2, 1'b1, 1'b1, 1'b1, 32'd2100, 1'b0));
        send_event(make_item(3, 1'b1, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0));
        send_event(make_item(3, 1'b1, 1'b1, 1'b0, 32'hFFFF_FFFF, 1'b0));
        send_event(make_item(3, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0));
        send_event(make_item(3, 1'b1, 1'b0, 1'b0, 32'd10, 1'b0));
        send_event(make_item(3, 1'b1, 1'b0, 1'b0, 32'hFFFF_FFFF, 1'b0));
        send_event(make_item(3, 1'b1, 1'b1, 1'b1, 32'd1999, 1'b0));
        send_event(make_item(2, 1'b0, 1'b0, 1'b0, 32'h5555_AAAA, 1'b1));
        send_event(make_item(3, 1'b0, 1'b1, 1'b1, 32'hAAAA_5555, 1'b1));
        settle();

        settings[0] = '{32'd0, 32'd0, 16'd0, 2'd1};
        settings[1] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 2'd3};
        settings[2] = '{HOLD_THR_RST, BOOT_HOLD_THR_RST, DEBOUNCE_RST, BOOT_INDEX_RST};
        settings[3] = '{32'd300, 32'd1200, 16'd20, 2'd2};
        settings[4] = '{32'($urandom), 32'($urandom), 16'($urandom), 2'($urandom)};
        settings[5] = '{32'd100, 32'hFFFF_FFFF, 16'd0, 2'd1};

        for (int p = 0; p < 6; p++) begin
            gaps_on = (p != 2);
            apply_settings(settings[p]);
            repeat (PHASE_ITEMS) send_event(make_random_event());
            settle();
        end

        if (sb.mismatches == 0 && sb.expected_flags.size() == 0)
            $display("button_click_hold_classifier_top verification clean");
        else
            $display("button_click_hold_classifier_top verification failed");
        $finish;
    end
endmodule
